>>> hdl/mbd_pkg.sv
// shared types, character codes and decode functions for the mime body decoder
`default_nettype none
package mbd_pkg;

  localparam logic [1:0] ENC_PLAIN = 2'd0;
  localparam logic [1:0] ENC_QP    = 2'd1;
  localparam logic [1:0] ENC_B64   = 2'd2;

  localparam logic [1:0] ACT_BYTE = 2'd0;
  localparam logic [1:0] ACT_PART = 2'd1;
  localparam logic [1:0] ACT_MSG  = 2'd2;

  localparam logic [1:0] REG_ENCODING = 2'd0;
  localparam logic [1:0] REG_QUOTE    = 2'd1;

  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned MAX_BYTES  = 4;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;

  localparam logic [5:0] B64_PLUS  = 6'd62;
  localparam logic [5:0] B64_SLASH = 6'd63;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic       valid;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic       valid;
    logic       pad;
    logic [5:0] val;
  } b64_sym_t;

  // one queue entry: decoded bytes of one input item, or a message clear
  typedef struct packed {
    logic                            clr_msg;
    logic [2:0]                      n;
    logic [MAX_BYTES-1:0][7:0]       bytes;
  } entry_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.valid = 1'b1;
      h.val   = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.valid = 1'b1;
      h.val   = 4'(c[3:0] + 4'd9);
    end
    return h;
  endfunction

  function automatic b64_sym_t b64_decode(input logic [7:0] c);
    b64_sym_t s;
    s = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s.valid = 1'b1;
      s.val   = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s.valid = 1'b1;
      s.val   = 6'(c - 8'd71);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.valid = 1'b1;
      s.val   = 6'(c + 8'd4);
    end else if (c == CH_PLUS) begin
      s.valid = 1'b1;
      s.val   = B64_PLUS;
    end else if (c == CH_SLASH) begin
      s.valid = 1'b1;
      s.val   = B64_SLASH;
    end else if (c == CH_EQ) begin
      s.valid = 1'b1;
      s.pad   = 1'b1;
    end
    return s;
  endfunction

  function automatic logic is_line_end(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF) || (c == CH_NUL);
  endfunction

endpackage
`default_nettype wire

>>> hdl/mbd_if.sv
// channel interfaces: input items, result bytes, register writes
`default_nettype none
interface mbd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;
  logic       line_last;
  modport source (output valid, action, data_byte, line_last, input ready);
  modport sink   (input valid, action, data_byte, line_last, output ready);
endinterface

interface mbd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        last_of_run;
  logic [31:0] body_count;
  modport source (output valid, out_byte, last_of_run, body_count, input ready);
  modport sink   (input valid, out_byte, last_of_run, body_count, output ready);
endinterface

interface mbd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      index;
  logic [mbd_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hdl/mbd_fifo.sv
// small register queue between front and back
`default_nettype none
module mbd_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire mbd_pkg::entry_t push_data,
  input  wire logic            pop,
  output mbd_pkg::entry_t      head,
  output logic                 empty,
  output logic                 full
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  mbd_pkg::entry_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CW'(DEPTH));
  assign head  = mem_r[rd_ptr_r];

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : AW'(p + 1'b1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wrap_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= CW'(cnt_r + 1'b1);
      end else if (pop && !push) begin
        cnt_r <= CW'(cnt_r - 1'b1);
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("pop from empty queue");
endmodule
`default_nettype wire

>>> hdl/mbd_front.sv
// front: accepts input beats, runs qp/base64 decode, queues decoded bytes
`default_nettype none
module mbd_front (
  input  wire logic       clk,
  input  wire logic       rst_n,
  mbd_in_if.sink          in_ch,
  input  wire logic [1:0] encoding,
  input  wire logic       q_full,
  output logic            q_push,
  output mbd_pkg::entry_t q_data
);
  logic [1:0]  qp_stage_r, qp_stage_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [23:0] word_r, word_nxt;
  logic [2:0]  sym_r, sym_nxt;
  logic [4:0]  bits_r, bits_nxt;
  logic        lfin_r, lfin_nxt;
  logic        acc;

  assign in_ch.ready = !q_full;
  assign acc = in_ch.valid && in_ch.ready;

  always_comb begin
    mbd_pkg::entry_t e;
    mbd_pkg::hex_t   hc, hh;
    mbd_pkg::b64_sym_t bs;
    logic [7:0] c;
    logic norm;
    c = in_ch.data_byte;
    e = '0;
    norm = 1'b0;
    hc = mbd_pkg::hex_decode(c);
    hh = mbd_pkg::hex_decode(held_r);
    bs = mbd_pkg::b64_decode(c);
    qp_stage_nxt = qp_stage_r;
    held_nxt = held_r;
    word_nxt = word_r;
    sym_nxt  = sym_r;
    bits_nxt = bits_r;
    lfin_nxt = lfin_r;
    case (in_ch.action)
      mbd_pkg::ACT_PART, mbd_pkg::ACT_MSG: begin
        qp_stage_nxt = '0;
        held_nxt = '0;
        word_nxt = '0;
        sym_nxt  = '0;
        bits_nxt = '0;
        lfin_nxt = 1'b0;
        e.clr_msg = (in_ch.action == mbd_pkg::ACT_MSG);
      end
      mbd_pkg::ACT_BYTE: begin
        if (!lfin_r) begin
          case (encoding)
            mbd_pkg::ENC_QP: begin
              case (qp_stage_r)
                2'd1: begin
                  if (hc.valid) begin
                    held_nxt = c;
                    qp_stage_nxt = 2'd2;
                  end else if (mbd_pkg::is_line_end(c)) begin
                    qp_stage_nxt = 2'd0;
                    lfin_nxt = 1'b1;
                  end else begin
                    e.bytes[e.n[1:0]] = mbd_pkg::CH_EQ;
                    e.n = e.n + 3'd1;
                    qp_stage_nxt = 2'd0;
                    norm = 1'b1;
                  end
                end
                2'd2: begin
                  qp_stage_nxt = 2'd0;
                  if (hc.valid) begin
                    e.bytes[e.n[1:0]] = {hh.val, hc.val};
                    e.n = e.n + 3'd1;
                  end else begin
                    e.bytes[e.n[1:0]] = mbd_pkg::CH_EQ;
                    e.n = e.n + 3'd1;
                    e.bytes[e.n[1:0]] = held_r;
                    e.n = e.n + 3'd1;
                    norm = 1'b1;
                  end
                end
                default: begin
                  qp_stage_nxt = 2'd0;
                  norm = 1'b1;
                end
              endcase
              if (norm) begin
                if (mbd_pkg::is_line_end(c)) begin
                  e.bytes[e.n[1:0]] = mbd_pkg::CH_LF;
                  e.n = e.n + 3'd1;
                  lfin_nxt = 1'b1;
                end else if (c == mbd_pkg::CH_EQ) begin
                  qp_stage_nxt = 2'd1;
                end else begin
                  e.bytes[e.n[1:0]] = c;
                  e.n = e.n + 3'd1;
                end
              end
              // unterminated line end
              if (in_ch.line_last && !lfin_nxt) begin
                if (qp_stage_nxt == 2'd2) begin
                  e.bytes[e.n[1:0]] = mbd_pkg::CH_EQ;
                  e.n = e.n + 3'd1;
                  e.bytes[e.n[1:0]] = held_nxt;
                  e.n = e.n + 3'd1;
                  e.bytes[e.n[1:0]] = mbd_pkg::CH_LF;
                  e.n = e.n + 3'd1;
                end else if (qp_stage_nxt == 2'd0) begin
                  e.bytes[e.n[1:0]] = mbd_pkg::CH_LF;
                  e.n = e.n + 3'd1;
                end
                qp_stage_nxt = 2'd0;
              end
            end
            mbd_pkg::ENC_B64: begin
              if (c == mbd_pkg::CH_NUL) begin
                lfin_nxt = 1'b1;
              end else if (bs.valid) begin
                word_nxt = {word_r[17:0], bs.pad ? 6'd0 : bs.val};
                bits_nxt = bs.pad ? bits_r : 5'(bits_r + 5'd6);
                sym_nxt  = 3'(sym_r + 3'd1);
                if (sym_nxt >= 3'd4) begin
                  if (bits_nxt >= 5'd8) begin
                    e.bytes[e.n[1:0]] = word_nxt[23:16];
                    e.n = e.n + 3'd1;
                  end
                  if (bits_nxt >= 5'd16) begin
                    e.bytes[e.n[1:0]] = word_nxt[15:8];
                    e.n = e.n + 3'd1;
                  end
                  if (bits_nxt >= 5'd24) begin
                    e.bytes[e.n[1:0]] = word_nxt[7:0];
                    e.n = e.n + 3'd1;
                  end
                  sym_nxt  = '0;
                  bits_nxt = '0;
                end
              end
            end
            default: begin
              if (c == mbd_pkg::CH_NUL) begin
                lfin_nxt = 1'b1;
              end else begin
                e.bytes[e.n[1:0]] = c;
                e.n = e.n + 3'd1;
              end
            end
          endcase
        end
        if (in_ch.line_last) begin
          lfin_nxt = 1'b0;
        end
      end
      default: ;
    endcase
    q_data = e;
    q_push = acc && (e.n != 3'd0 || e.clr_msg);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qp_stage_r <= '0;
      held_r     <= '0;
      word_r     <= '0;
      sym_r      <= '0;
      bits_r     <= '0;
      lfin_r     <= 1'b0;
    end else if (acc) begin
      qp_stage_r <= qp_stage_nxt;
      held_r     <= held_nxt;
      word_r     <= word_nxt;
      sym_r      <= sym_nxt;
      bits_r     <= bits_nxt;
      lfin_r     <= lfin_nxt;
    end
  end

  a_last_clears_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_ch.action == mbd_pkg::ACT_BYTE && in_ch.line_last) |=> !lfin_r)
    else $error("line drop survived line end");
  a_held_is_hex: assert property (@(posedge clk) disable iff (!rst_n)
    (qp_stage_r == 2'd2) |-> mbd_pkg::hex_decode(held_r).valid)
    else $error("held char not a hex digit");
  a_b64_sym_range: assert property (@(posedge clk) disable iff (!rst_n)
    (sym_r < 3'd4) && (bits_r <= 5'd18))
    else $error("base64 collector out of range");
endmodule
`default_nettype wire

>>> hdl/mbd_back.sv
// back: expands queued bytes with quote prefix, counts and registers results
`default_nettype none
module mbd_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            quote_en,
  input  wire mbd_pkg::entry_t head,
  input  wire logic            q_empty,
  output logic                 q_pop,
  mbd_out_if.source            out_ch
);
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;
  logic [31:0] count_r, count_nxt;
  logic        als_r, als_nxt;
  logic        sp_r, sp_nxt;
  logic [1:0]  idx_r, idx_nxt;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.last_of_run = out_last_r;
  assign out_ch.body_count  = count_r;

  always_comb begin
    logic [7:0] b;
    logic adv, emit;
    b = head.bytes[idx_r];
    adv = !out_valid_r || out_ch.ready;
    emit = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    count_nxt = count_r;
    als_nxt = als_r;
    sp_nxt  = sp_r;
    idx_nxt = idx_r;
    q_pop   = 1'b0;
    if (adv && !q_empty) begin
      if (head.clr_msg) begin
        als_nxt = 1'b1;
        count_nxt = '0;
        q_pop = 1'b1;
      end else if (quote_en && als_r && !sp_r) begin
        emit = 1'b1;
        out_byte_nxt = mbd_pkg::CH_GT;
        out_last_nxt = 1'b0;
        als_nxt = 1'b0;
        sp_nxt = (b != mbd_pkg::CH_LF) && (b != mbd_pkg::CH_CR);
      end else if (sp_r) begin
        emit = 1'b1;
        out_byte_nxt = mbd_pkg::CH_SP;
        out_last_nxt = 1'b0;
        sp_nxt = 1'b0;
      end else begin
        emit = 1'b1;
        out_byte_nxt = b;
        if (b == mbd_pkg::CH_LF) begin
          als_nxt = 1'b1;
        end
        if (idx_r == 2'(head.n - 3'd1)) begin
          out_last_nxt = 1'b1;
          idx_nxt = '0;
          q_pop = 1'b1;
        end else begin
          out_last_nxt = 1'b0;
          idx_nxt = 2'(idx_r + 2'd1);
        end
      end
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      if (count_r != mbd_pkg::COUNT_MAX) begin
        count_nxt = 32'(count_r + 32'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r <= '0;
      als_r   <= 1'b1;
      sp_r    <= 1'b0;
      idx_r   <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      count_r <= count_nxt;
      als_r   <= als_nxt;
      sp_r    <= sp_nxt;
      idx_r   <= idx_nxt;
    end
  end

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (count_r != '0))
    else $error("result beat with zero count");
  a_space_after_gt: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r |-> (out_valid_r && out_byte_r == mbd_pkg::CH_GT && !out_last_r))
    else $error("pending space without marker");
  a_prefix_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> !sp_r)
    else $error("run ended inside prefix");
endmodule
`default_nettype wire

>>> hdl/mime_body_decoder_top.sv
// top level of the mime body decoder: config registers, front, queue, back
//
//  channel  dir  beat                                   handshake
//  in_ch    in   action, data_byte, line_last           valid/ready
//  out_ch   out  out_byte, last_of_run, body_count      valid/ready
//  cfg_ch   in   index, data                            valid/ready (always ready)
//
// the front takes one input beat per cycle while the queue has room
// the back sends one result beat per cycle while out_ch is ready; an item yields
// 0 to 6 result bytes, prefix bytes included, and a new-message beat yields none
// synchronous active-low reset; registers reset to plain mode, quoting off
// a stalled output only backs up the queue; the front keeps accepting until it fills
`default_nettype none
module mime_body_decoder_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mbd_in_if.sink    in_ch,
  mbd_out_if.source out_ch,
  mbd_cfg_if.sink   cfg_ch
);
  logic [1:0]      enc_r;
  logic            quote_r;
  logic            q_push, q_pop, q_empty, q_full;
  mbd_pkg::entry_t q_data, q_head;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_r   <= mbd_pkg::ENC_PLAIN;
      quote_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        mbd_pkg::REG_ENCODING: enc_r   <= cfg_ch.data[1:0];
        mbd_pkg::REG_QUOTE:    quote_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  mbd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .encoding (enc_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_data)
  );

  mbd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  mbd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .quote_en (quote_r),
    .head     (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_ch   (out_ch)
  );
endmodule
`default_nettype wire
